// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

  localparam int unsigned DEPTH_DEF        = 16;
  localparam int unsigned PAYLOAD_BITS_DEF = 16;

  localparam int unsigned PRIO_W = 2;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned PAY_W  = 16;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [PRIO_W-1:0] PRIO_LOW      = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_CRITICAL = 2'd3;

  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_POPPED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PRIO_W-1:0] prio;
  } cell_cmd_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
module spq_cell #(
  parameter int unsigned PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  spq_pkg::cell_cmd_t          cmd,
  input  logic [PAYLOAD_BITS-1:0]     new_payload,
  // left neighbour (higher rank)
  input  logic                        left_valid,
  input  logic                        left_keep,
  input  logic [spq_pkg::PRIO_W-1:0]  left_prio,
  input  logic [PAYLOAD_BITS-1:0]     left_payload,
  // right neighbour (lower rank)
  input  logic                        right_valid,
  input  logic [spq_pkg::PRIO_W-1:0]  right_prio,
  input  logic [PAYLOAD_BITS-1:0]     right_payload,
  output logic                        valid,
  output logic                        keep,
  output logic [spq_pkg::PRIO_W-1:0]  prio,
  output logic [PAYLOAD_BITS-1:0]     payload
);

  // Chain is kept sorted: priority descending, arrival order within a level.
  // A new entry goes behind everything of equal or higher priority.
  assign keep = valid && (prio >= cmd.prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.pop) begin
      valid <= right_valid;
    end else if (cmd.push) begin
      valid <= valid | left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      prio    <= right_prio;
      payload <= right_payload;
    end else if (cmd.push && !keep) begin
      if (left_keep) begin
        prio    <= cmd.prio;
        payload <= new_payload;
      end else begin
        prio    <= left_prio;
        payload <= left_payload;
      end
    end
  end

endmodule

// ----- rtl/core/stable_priority_queue_unit.sv -----
// Stable four-level priority queue of task handles.
// Input channel (in_valid/in_ready): op 0 pushes {priority_req, payload},
// op 1 pops the oldest entry of the highest priority held.
// Output channel (out_valid/out_ready): one result per transaction with
// status, popped payload/priority (zero unless popped) and occupancy.
// Push when full is rejected (status full), pop when empty is flagged.
// Entries live in a chain of DEPTH cells kept sorted by priority, then by
// arrival; a push inserts the new entry, a pop shifts the chain down by one.
// An input transaction passes the command register, then the chain update
// with the result registered. Throughput: one transaction per cycle while
// out_ready is high.
// A command waiting behind a stalled result is held in the command register,
// so one further input transaction is taken while a result waits.
// Reset (rst, synchronous) empties the queue and clears both channels.
module stable_priority_queue_unit #(
  parameter int unsigned DEPTH        = spq_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [spq_pkg::PRIO_W-1:0]  priority_req,
  input  logic [spq_pkg::PAY_W-1:0]   payload,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [spq_pkg::PAY_W-1:0]   out_payload,
  output logic [spq_pkg::PRIO_W-1:0]  out_priority,
  output logic [spq_pkg::OCC_W-1:0]   occupancy
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // command register
  logic                        cmd_valid;
  logic                        cmd_op;
  logic [spq_pkg::PRIO_W-1:0]  cmd_prio;
  logic [PAYLOAD_BITS-1:0]     cmd_payload;
  logic [PAYLOAD_BITS-1:0]     payload_ext;

  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic [spq_pkg::OCC_W-1:0]   occ_next;
  logic [spq_pkg::PAY_W-1:0]   head_payload;

  logic                        proceed;
  logic                        full;
  logic                        empty;
  spq_pkg::cell_cmd_t          cell_cmd;

  logic [DEPTH-1:0]            cell_valid;
  logic [DEPTH-1:0]            cell_keep;
  logic [spq_pkg::PRIO_W-1:0]  cell_prio    [DEPTH];
  logic [PAYLOAD_BITS-1:0]     cell_payload [DEPTH];

  assign proceed  = cmd_valid && (!out_valid || out_ready);
  assign in_ready = !cmd_valid || proceed;
  assign full     = cell_valid[DEPTH-1];
  assign empty    = !cell_valid[0];

  generate
    if (PAYLOAD_BITS >= spq_pkg::PAY_W) begin : g_pay_wide
      assign payload_ext  = {{(PAYLOAD_BITS - spq_pkg::PAY_W){1'b0}}, payload};
      assign head_payload = cell_payload[0][spq_pkg::PAY_W-1:0];
    end else begin : g_pay_narrow
      assign payload_ext  = payload[PAYLOAD_BITS-1:0];
      assign head_payload = {{(spq_pkg::PAY_W - PAYLOAD_BITS){1'b0}}, cell_payload[0]};
    end
    if (CNT_W >= spq_pkg::OCC_W) begin : g_occ_wide
      assign occ_next = count_next[spq_pkg::OCC_W-1:0];
    end else begin : g_occ_narrow
      assign occ_next = {{(spq_pkg::OCC_W - CNT_W){1'b0}}, count_next};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_op      <= op;
      cmd_prio    <= priority_req;
      cmd_payload <= payload_ext;
    end
  end

  always_comb begin
    cell_cmd.push = proceed && (cmd_op == spq_pkg::OP_PUSH) && !full;
    cell_cmd.pop  = proceed && (cmd_op == spq_pkg::OP_POP) && !empty;
    cell_cmd.prio = cmd_prio;
  end

  always_comb begin
    count_next = count;
    if (cell_cmd.push) begin
      count_next = count + CNT_W'(1);
    end else if (cell_cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // chain of cells; cell 0 holds the next entry to leave
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                        l_valid;
      logic                        l_keep;
      logic [spq_pkg::PRIO_W-1:0]  l_prio;
      logic [PAYLOAD_BITS-1:0]     l_payload;
      logic                        r_valid;
      logic [spq_pkg::PRIO_W-1:0]  r_prio;
      logic [PAYLOAD_BITS-1:0]     r_payload;

      if (i == 0) begin : g_head
        // virtual sentinel ahead of the chain always keeps its place
        assign l_valid   = 1'b1;
        assign l_keep    = 1'b1;
        assign l_prio    = spq_pkg::PRIO_CRITICAL;
        assign l_payload = '0;
      end else begin : g_mid_l
        assign l_valid   = cell_valid[i-1];
        assign l_keep    = cell_keep[i-1];
        assign l_prio    = cell_prio[i-1];
        assign l_payload = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_valid   = 1'b0;
        assign r_prio    = spq_pkg::PRIO_LOW;
        assign r_payload = '0;
      end else begin : g_mid_r
        assign r_valid   = cell_valid[i+1];
        assign r_prio    = cell_prio[i+1];
        assign r_payload = cell_payload[i+1];
      end

      spq_cell #(
        .PAYLOAD_BITS(PAYLOAD_BITS)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .cmd          (cell_cmd),
        .new_payload  (cmd_payload),
        .left_valid   (l_valid),
        .left_keep    (l_keep),
        .left_prio    (l_prio),
        .left_payload (l_payload),
        .right_valid  (r_valid),
        .right_prio   (r_prio),
        .right_payload(r_payload),
        .valid        (cell_valid[i]),
        .keep         (cell_keep[i]),
        .prio         (cell_prio[i]),
        .payload      (cell_payload[i])
      );
    end
  endgenerate

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      occupancy    <= occ_next;
      out_payload  <= '0;
      out_priority <= spq_pkg::PRIO_LOW;
      if (cmd_op == spq_pkg::OP_PUSH) begin
        status <= full ? spq_pkg::ST_FULL : spq_pkg::ST_PUSHED;
      end else if (empty) begin
        status <= spq_pkg::ST_EMPTY;
      end else begin
        status       <= spq_pkg::ST_POPPED;
        out_payload  <= head_payload;
        out_priority <= cell_prio[0];
      end
    end
  end

endmodule

// ----- rtl/core/spq_checker.sv -----
module spq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status,
  input logic [spq_pkg::PAY_W-1:0]   out_payload,
  input logic [spq_pkg::PRIO_W-1:0]  out_priority,
  input logic [spq_pkg::OCC_W-1:0]   occupancy
);

  // only a pop that found an entry carries data
  a_no_data_unless_popped: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != spq_pkg::ST_POPPED) |->
      (out_payload == '0) && (out_priority == spq_pkg::PRIO_LOW))
    else $error("data on a result that is not a pop");

  a_empty_occupancy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::ST_EMPTY) |-> (occupancy == '0))
    else $error("pop on empty reports entries held");

  // a push that went in leaves at least one entry
  a_push_occupancy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::ST_PUSHED) |-> (occupancy != '0))
    else $error("push reports an empty queue");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(out_payload) && $stable(out_priority) && $stable(occupancy))
    else $error("stalled result changed");

  // nothing on the output in the first cycle after reset is released
  a_no_result_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result straight after reset");

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .out_payload (out_payload),
  .out_priority(out_priority),
  .occupancy   (occupancy)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int QUEUE_DEPTH = spq_pkg::DEPTH_DEF;
  localparam logic [spq_pkg::PRIO_W-1:0] PRIO_NORMAL = 2'd1;
  localparam logic [spq_pkg::PRIO_W-1:0] PRIO_HIGH   = 2'd2;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic                       op;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::PAY_W-1:0]  payload;
  } request_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [spq_pkg::PAY_W-1:0]  payload;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::OCC_W-1:0]  occupancy;
  } outcome_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       op = spq_pkg::OP_PUSH;
  logic [spq_pkg::PRIO_W-1:0] priority_req = spq_pkg::PRIO_LOW;
  logic [spq_pkg::PAY_W-1:0]  payload = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 status;
  logic [spq_pkg::PAY_W-1:0]  out_payload;
  logic [spq_pkg::PRIO_W-1:0] out_priority;
  logic [spq_pkg::OCC_W-1:0]  occupancy;

  stable_priority_queue_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .priority_req (priority_req),
    .payload      (payload),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_payload  (out_payload),
    .out_priority (out_priority),
    .occupancy    (occupancy)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // queue contents in arrival order, mirrored from accepted transactions
  logic [spq_pkg::PAY_W-1:0]  held_pay  [QUEUE_DEPTH];
  logic [spq_pkg::PRIO_W-1:0] held_prio [QUEUE_DEPTH];
  int held_n = 0;

  request_t pending_requests[$];
  outcome_t awaited_outcomes[$];

  int requests_taken = 0;
  int outcomes_checked = 0;
  int error_count = 0;
  int pushes_seen = 0, pops_seen = 0, full_seen = 0, empty_seen = 0;
  int deepest = 0;

  function automatic outcome_t apply_request(request_t r);
    outcome_t res;
    int best;
    res = '0;
    if (r.op == spq_pkg::OP_PUSH) begin
      if (held_n >= QUEUE_DEPTH) begin
        res.status = spq_pkg::ST_FULL;
        full_seen++;
      end else begin
        held_pay[held_n]  = r.payload;
        held_prio[held_n] = r.prio;
        held_n++;
        res.status = spq_pkg::ST_PUSHED;
        pushes_seen++;
      end
    end else begin
      if (held_n == 0) begin
        res.status = spq_pkg::ST_EMPTY;
        empty_seen++;
      end else begin
        // strict compare keeps the oldest among equal priorities
        best = 0;
        for (int i = 1; i < held_n; i++)
          if (held_prio[i] > held_prio[best]) best = i;
        res.payload = held_pay[best];
        res.prio    = held_prio[best];
        for (int i = best; i + 1 < held_n; i++) begin
          held_pay[i]  = held_pay[i + 1];
          held_prio[i] = held_prio[i + 1];
        end
        held_n--;
        res.status = spq_pkg::ST_POPPED;
        pops_seen++;
      end
    end
    if (held_n > deepest) deepest = held_n;
    res.occupancy = held_n[spq_pkg::OCC_W-1:0];
    return res;
  endfunction

  task automatic add_request(input logic o, input logic [spq_pkg::PRIO_W-1:0] p,
                             input logic [spq_pkg::PAY_W-1:0] d);
    request_t r;
    r.op = o;
    r.prio = p;
    r.payload = d;
    pending_requests = {pending_requests, r};
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      error_count++;
      $display("%0t: %s mismatch on transaction %0d: expected %0h, actual %0h",
               $time, name, outcomes_checked, exp_v, act_v);
    end
  endtask

  // sender: no gaps for a stretch of the random part
  always @(posedge clk) begin : driver
    request_t next_req;
    bit steady;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_outcomes = {awaited_outcomes,
                            apply_request({op, priority_req, payload})};
        requests_taken++;
      end
      steady = (requests_taken >= 700 && requests_taken < 1000);
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
          next_req = pending_requests.pop_front();
          in_valid     <= 1'b1;
          op           <= next_req.op;
          priority_req <= next_req.prio;
          payload      <= next_req.payload;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off to back up the block
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && outcomes_checked >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 80;
      out_ready <= 1'b0;
    end else if (outcomes_checked >= 700 && outcomes_checked < 1000) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin : monitor
    outcome_t exp_o;
    if (!rst && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transaction: expected none, actual status %0d",
                 $time, status);
      end else begin
        exp_o = awaited_outcomes.pop_front();
        check_field("status",       exp_o.status,    status);
        check_field("out_payload",  exp_o.payload,   out_payload);
        check_field("out_priority", exp_o.prio,      out_priority);
        check_field("occupancy",    exp_o.occupancy, occupancy);
        outcomes_checked++;
      end
    end
  end

  initial begin : stimulus
    int count;
    int run_len;
    int push_bias;
    int pick;
    logic [spq_pkg::PAY_W-1:0] d;

    // directed: empty pop, fill with mixed priorities and ties, full push, drain a few
    add_request(spq_pkg::OP_POP, spq_pkg::PRIO_CRITICAL, 16'hFFFF);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == 0)      d = 16'hFFFF;
      else if (i == 1) d = 16'h0000;
      else             d = 16'(i * 16'h1357);
      add_request(spq_pkg::OP_PUSH, 2'((i * 3) % 4), d);
    end
    add_request(spq_pkg::OP_PUSH, PRIO_HIGH, 16'hA5A5);
    repeat (5) add_request(spq_pkg::OP_POP, spq_pkg::PRIO_LOW, 16'h0000);

    // random: phases leaning to push or pop so that full and empty are both reached
    count = 0;
    while (count < RANDOM_ITEMS) begin
      run_len = $urandom_range(40, 8);
      pick = $urandom_range(2);
      push_bias = (pick == 0) ? 85 : (pick == 1) ? 50 : 15;
      for (int k = 0; k < run_len; k++) begin
        pick = $urandom_range(15);
        d = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        add_request(($urandom_range(99) < push_bias) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP,
                    2'($urandom_range(3)), d);
        count++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() > 0 || in_valid) @(posedge clk);
    while (awaited_outcomes.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d transactions: %0d pushes, %0d pops, %0d rejected when full,",
             requests_taken, pushes_seen, pops_seen, full_seen);
    $display("%0d pops on empty, peak occupancy %0d, %0d results checked, %0d errors.",
             empty_seen, deepest, outcomes_checked, error_count);
    if (error_count == 0) begin
      $display("stable_priority_queue_unit regression: pass");
    end else begin
      $display("stable_priority_queue_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timed out with %0d results still awaited", awaited_outcomes.size());
    $display("stable_priority_queue_unit regression: fail");
    $finish;
  end

endmodule
